// File: rtl/mvmt_pkg.sv
`timescale 1ns / 1ps

package mvmt_pkg;

    localparam int DIM_W     = 10;
    localparam int MAX_DIM   = 1024;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;
    localparam int QDEPTH    = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS  = 2'd0,
        CFG_NUM_COLS  = 2'd1,
        CFG_TRANSPOSE = 2'd2
    } cfg_reg_t;

    // per-element control carried from front to back
    typedef struct packed {
        logic [DIM_W-1:0] col;        // column sum address
        logic [DIM_W-1:0] res_index;  // row (normal) or column (transpose)
        logic             mode;       // 1: transpose
        logic             first;      // start a fresh sum
        logic             emit;       // this element completes a result
        logic             last;       // final result of the pass
    } mvmt_ctl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] mat;
        logic signed [VAL_W-1:0] vec;
        mvmt_ctl_t               ctl;
    } mvmt_item_t;

    // saturating signed add on two's-complement patterns
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        begin
            s = a + b;
            if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
                return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
            end
            return s;
        end
    endfunction

    // last valid index of a dimension; 0 acts as 1, above MAX_DIM as MAX_DIM
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] e;
        begin
            if (r == '0) begin
                e = CFG_W'(1);
            end else if (r > CFG_W'(MAX_DIM)) begin
                e = CFG_W'(MAX_DIM);
            end else begin
                e = r;
            end
            return DIM_W'(e - CFG_W'(1));
        end
    endfunction

endpackage

// File: rtl/mvmt_front.sv
`timescale 1ns / 1ps

module mvmt_front import mvmt_pkg::*; #(
    parameter int VEC_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [DIM_W-1:0]     s_vec_index,
    input  logic [VAL_W-1:0]     s_value,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 q_full,
    output logic                 q_push,
    output mvmt_item_t           q_item
);

    localparam int AW = $clog2(VEC_DEPTH);

    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic             transpose_reg;
    logic             cfg_hit;

    logic [DIM_W-1:0] row_count_reg, row_count_next;
    logic [DIM_W-1:0] col_count_reg, col_count_next;
    logic [DIM_W-1:0] rows_last, cols_last;
    logic             row_end, col_end;

    logic             mat_acc, ld_acc;
    logic [DIM_W-1:0] rd_idx;
    logic             rd_ok, wr_ok;

    logic [VAL_W-1:0] vec_mem [VEC_DEPTH];
    logic [VAL_W-1:0] vec_rd_reg;
    logic             rd_ok_reg;

    logic             s1_valid_reg;
    mvmt_item_t       s1_item_reg;

    always_comb begin
        unique case (cfg_wr_index)
            CFG_NUM_ROWS, CFG_NUM_COLS, CFG_TRANSPOSE: cfg_hit = 1'b1;
            default:                                   cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg  <= CFG_W'(1);
            num_cols_reg  <= CFG_W'(1);
            transpose_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_NUM_ROWS:  num_rows_reg  <= cfg_wr_data;
                CFG_NUM_COLS:  num_cols_reg  <= cfg_wr_data;
                CFG_TRANSPOSE: transpose_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign rows_last = dim_last(num_rows_reg);
    assign cols_last = dim_last(num_cols_reg);
    assign row_end   = (row_count_reg == rows_last);
    assign col_end   = (col_count_reg == cols_last);

    assign q_push  = s1_valid_reg && !q_full;
    assign s_ready = !s1_valid_reg || q_push;
    assign mat_acc = s_valid && s_ready && s_kind;
    assign ld_acc  = s_valid && s_ready && !s_kind;

    // step the element position; any register write restarts the pass
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        priority if (cfg_wr_en && cfg_hit) begin
            row_count_next = '0;
            col_count_next = '0;
        end else if (mat_acc) begin
            if (col_end) begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row_count_reg + DIM_W'(1);
            end else begin
                col_count_next = col_count_reg + DIM_W'(1);
            end
        end else begin
            // hold the position
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    assign rd_idx = transpose_reg ? row_count_reg : col_count_reg;
    assign rd_ok  = 32'(rd_idx) < 32'(VEC_DEPTH);
    assign wr_ok  = 32'(s_vec_index) < 32'(VEC_DEPTH);

    always_ff @(posedge aclk) begin
        if (ld_acc && wr_ok) begin
            vec_mem[AW'(s_vec_index)] <= s_value;
        end
        if (mat_acc) begin
            vec_rd_reg <= vec_mem[AW'(rd_idx)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (mat_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (q_push) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mat_acc) begin
            rd_ok_reg                 <= rd_ok;
            s1_item_reg.mat           <= s_value;
            s1_item_reg.vec           <= '0;
            s1_item_reg.ctl.col       <= col_count_reg;
            s1_item_reg.ctl.res_index <= transpose_reg ? col_count_reg : row_count_reg;
            s1_item_reg.ctl.mode      <= transpose_reg;
            s1_item_reg.ctl.first     <= transpose_reg ? (row_count_reg == '0)
                                                       : (col_count_reg == '0);
            s1_item_reg.ctl.emit      <= transpose_reg ? row_end : col_end;
            s1_item_reg.ctl.last      <= transpose_reg ? col_end : row_end;
        end
    end

    // positions beyond the vector store read as zero
    always_comb begin
        q_item     = s1_item_reg;
        q_item.vec = rd_ok_reg ? vec_rd_reg : '0;
    end

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_count_reg <= cols_last)
        else $error("column position past the last column");

    a_load_holds_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_acc && !cfg_wr_en |=> $stable(row_count_reg) && $stable(col_count_reg))
        else $error("vector load moved the element position");

endmodule

// File: rtl/mvmt_queue.sv
`timescale 1ns / 1ps

module mvmt_queue import mvmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  mvmt_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output mvmt_item_t head
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    mvmt_item_t    slot_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from an empty queue");

endmodule

// File: rtl/mvmt_back.sv
`timescale 1ns / 1ps

module mvmt_back import mvmt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  mvmt_item_t       q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SUM_W-1:0] m_value,
    output logic [DIM_W-1:0] m_index,
    output logic             m_last
);

    logic signed [SUM_W-1:0] prod;
    logic                    b_valid_reg;
    logic        [SUM_W-1:0] b_prod_reg;
    mvmt_ctl_t               b_ctl_reg;
    logic                    b_adv;

    logic [SUM_W-1:0] col_mem [MAX_DIM];
    logic [SUM_W-1:0] col_rd_reg;
    logic             fwd_valid_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] base, sum;

    logic             out_valid_reg;
    logic [SUM_W-1:0] out_value_reg;
    logic [DIM_W-1:0] out_index_reg;
    logic             out_last_reg;

    assign b_adv = b_valid_reg && (!out_valid_reg || m_ready);
    assign q_pop = !q_empty && (!b_valid_reg || b_adv);
    assign prod  = q_head.mat * q_head.vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (q_pop) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    // the column sum read happens as an element enters; when the element
    // leaving in the same cycle writes that column, take its sum instead
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (q_pop) begin
            fwd_valid_reg <= b_adv && b_ctl_reg.mode && (b_ctl_reg.col == q_head.ctl.col);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_prod_reg <= SUM_W'(prod);
            b_ctl_reg  <= q_head.ctl;
            col_rd_reg <= col_mem[q_head.ctl.col];
        end
        if (b_adv && b_ctl_reg.mode) begin
            col_mem[b_ctl_reg.col] <= sum;
        end
    end

    always_comb begin
        if (b_ctl_reg.mode) begin
            base = fwd_valid_reg ? acc_reg : col_rd_reg;
        end else begin
            base = acc_reg;
        end
        sum = b_ctl_reg.first ? b_prod_reg : sat_add(base, b_prod_reg);
    end

    // acc holds the latest sum: the running row sum, or the column just written
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            acc_reg <= sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (b_adv && b_ctl_reg.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_ctl_reg.emit) begin
            out_value_reg <= sum;
            out_index_reg <= b_ctl_reg.res_index;
            out_last_reg  <= b_ctl_reg.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_index = out_index_reg;
    assign m_last  = out_last_reg;

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        b_adv && b_ctl_reg.emit |=> out_valid_reg)
        else $error("completed result not presented");

endmodule

// File: rtl/matrix_vector_multiply_transpose.sv
`timescale 1ns / 1ps

// Streaming matrix-vector multiplier: z = M*v, or z = M^T*v in transpose mode.
// Input words on s_*: tuser = 0 loads v[vec_index] = value; tuser = 1 delivers
// the next element of M in row-major order. Values are signed Q16.16, each
// product is exact and the Q32.32 sums saturate at every add.
// Result words on m_*: one per row (normal) or per column (transpose), emitted
// as the element that completes it passes; tlast marks the last one of a pass.
// Configuration: write num_rows, num_cols or transpose_mode on cfg_wr_*
// while the block is idle; any write restarts the pass.
// Throughput: one word per cycle, loads and matrix elements alike, while s_tready is high.
// A completing element reaches m_tvalid through the front stage (vector store read),
// the queue, the back stage (multiply, column sum read), then the output register.
// Reset: position back to row 0 / column 0, dims 1 x 1, normal mode. The
// vector store and column sum memory are not cleared; load v before use.
// When m_tready is low, the output register holds, then the back stage, a 4-entry queue
// and the front stage fill before s_tready drops.

module matrix_vector_multiply_transpose import mvmt_pkg::*; #(
    parameter int VEC_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // vec_index[9:0], value[41:10], zero pad
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // result_value[63:0], result_index[73:64], pad
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    logic             q_full, q_empty, q_push, q_pop;
    mvmt_item_t       q_item, q_head;
    logic [SUM_W-1:0] m_value;
    logic [DIM_W-1:0] m_index;

    mvmt_front #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_kind       (s_tuser),
        .s_vec_index  (s_tdata[DIM_W-1:0]),
        .s_value      (s_tdata[DIM_W+VAL_W-1:DIM_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    mvmt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    mvmt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_value (m_value),
        .m_index (m_index),
        .m_last  (m_tlast)
    );

    // pack result word, pad to whole bytes
    assign m_tdata = {6'b0, m_index, m_value};

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import mvmt_pkg::*;;

    // kind carried on s_tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    localparam int RANDOM_WORDS = 550;

    typedef struct packed {
        logic             kind;
        logic [DIM_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } word_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [DIM_W-1:0] index;
        logic             last;
    } sum_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;     // vec_index[9:0], value[41:10], zero pad
    logic                 s_tuser = 1'b0;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;          // result_value[63:0], result_index[73:64], pad
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = CFG_NUM_ROWS;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    matrix_vector_multiply_transpose dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the multiplier: vector store, column sums, position in
    // the pass and the three registers as last written (raw values).
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] vec_mem [MAX_DIM];
    logic [SUM_W-1:0] col_mem [MAX_DIM];
    int               at_row;
    int               at_col;
    logic [SUM_W-1:0] row_acc;
    logic [CFG_W-1:0] rows_raw = CFG_W'(1);
    logic [CFG_W-1:0] cols_raw = CFG_W'(1);
    logic             trans_mode = 1'b0;

    sum_t  sums_due[$];     // dot products still owed by the block
    word_t words_to_send[$];
    bit    failed = 1'b0;

    // stimulus side bookkeeping: which vector entries hold a value, and how
    // many matrix words have been queued since the last register write
    bit    vec_written [MAX_DIM];
    int    elems_queued;
    int    words_queued;

    // 0 acts as 1, anything above the largest dimension clamps to it
    function automatic int dim_of(input logic [CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > CFG_W'(MAX_DIM)) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] wide;
        wide = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        // top two bits disagree: the true sum left the 64-bit range
        if (wide[SUM_W] != wide[SUM_W-1])
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return wide[SUM_W-1:0];
    endfunction

    // update the shadow with one accepted word and queue the sum it completes
    task automatic accumulate_word(input word_t w);
        logic signed [SUM_W-1:0] mx;
        logic signed [SUM_W-1:0] vx;
        logic signed [SUM_W-1:0] prod;
        logic [SUM_W-1:0]        s;
        sum_t                    done;
        int                      nrows;
        int                      ncols;
        nrows = dim_of(rows_raw);
        ncols = dim_of(cols_raw);
        if (w.kind == KIND_LOAD) begin
            vec_mem[w.idx] = w.val;
            return;
        end
        mx = {{(SUM_W-VAL_W){w.val[VAL_W-1]}}, w.val};
        if (!trans_mode) begin
            vx = {{(SUM_W-VAL_W){vec_mem[at_col][VAL_W-1]}}, vec_mem[at_col]};
            prod = mx * vx;
            row_acc = add_sat(row_acc, prod);
            if (at_col + 1 >= ncols) begin
                done.sum = row_acc;
                done.index = DIM_W'(at_row);
                done.last = (at_row + 1 >= nrows);
                sums_due = {sums_due, done};
                row_acc = '0;
            end
        end else begin
            vx = {{(SUM_W-VAL_W){vec_mem[at_row][VAL_W-1]}}, vec_mem[at_row]};
            prod = mx * vx;
            // row 0 starts each column sum, later rows add to it
            s = (at_row == 0) ? prod : add_sat(col_mem[at_col], prod);
            col_mem[at_col] = s;
            if (at_row + 1 >= nrows) begin
                done.sum = s;
                done.index = DIM_W'(at_col);
                done.last = (at_col + 1 >= ncols);
                sums_due = {sums_due, done};
            end
        end
        // advance row-major position, wrap at end of pass
        at_col++;
        if (at_col >= ncols) begin
            at_col = 0;
            at_row++;
            if (at_row >= nrows) begin
                at_row = 0;
                row_acc = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one word per pending entry, random gap after each word,
    // with runs of back-to-back words when src_calm is set.
    // ------------------------------------------------------------------
    word_t cur_word;
    bit    word_taken = 1'b0;
    int    src_wait = 0;
    bit    src_calm = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            accumulate_word(cur_word);
            word_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // hold the word until it is taken
        end else if (src_wait > 0) begin
            src_wait--;
            s_tvalid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
            cur_word = words_to_send.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= cur_word.kind;
            s_tdata  <= {6'd0, cur_word.val, cur_word.idx};
            src_wait = src_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 40) == 0) src_calm = !src_calm;
        end else begin
            s_tvalid <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: compare every result word with the oldest owed sum, then
    // stall m_tready at random before the next one, with no stall while sink_calm is set.
    // ------------------------------------------------------------------
    sum_t want;
    int   sink_wait = 0;
    bit   sink_calm = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result word value %h index %0d last %b",
                         $time, m_tdata[63:0], m_tdata[73:64], m_tlast);
                failed = 1'b1;
            end else begin
                want = sums_due.pop_front();
                if (m_tdata[63:0] !== want.sum) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.sum, m_tdata[63:0]);
                    failed = 1'b1;
                end
                if (m_tdata[73:64] !== want.index) begin
                    $display("%0t: result_index expected %0d actual %0d",
                             $time, want.index, m_tdata[73:64]);
                    failed = 1'b1;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, m_tlast);
                    failed = 1'b1;
                end
            end
            sink_wait = sink_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Q16.16 value: extremes, near zero, or anything
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return VAL_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_extreme_dim();
        case ($urandom_range(0, 4))
            0: return CFG_W'(0);
            1: return CFG_W'(1024);
            2: return CFG_W'(1025);
            3: return CFG_W'(2047);
            default: return CFG_W'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic push_word(input logic kind, input logic [DIM_W-1:0] idx,
                             input logic [VAL_W-1:0] val);
        word_t w;
        w.kind = kind;
        w.idx = idx;
        w.val = val;
        words_to_send = {words_to_send, w};
        words_queued++;
    endtask

    task automatic push_load(input int idx, input logic [VAL_W-1:0] val);
        vec_written[idx] = 1'b1;
        push_word(KIND_LOAD, DIM_W'(idx), val);
    endtask

    // queue one matrix element; load the vector entry it reads first if
    // that entry has never held a value
    task automatic push_elem(input logic [VAL_W-1:0] val);
        int need;
        int nrows;
        int ncols;
        nrows = dim_of(rows_raw);
        ncols = dim_of(cols_raw);
        need = trans_mode ? (elems_queued / ncols) % nrows : elems_queued % ncols;
        if (!vec_written[need]) push_load(need, pick_value());
        push_word(KIND_ELEM, '0, val);
        elems_queued++;
    endtask

    // block until every word is in and every owed sum is out, then let the
    // pipeline drain loads that produce nothing
    task automatic wait_idle();
        while (words_to_send.size() != 0 || s_tvalid || sums_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= r;
        cfg_wr_data  <= d;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        case (r)
            CFG_NUM_ROWS:  rows_raw = d;
            CFG_NUM_COLS:  cols_raw = d;
            CFG_TRANSPOSE: trans_mode = d[0];
            default: ;
        endcase
        // every write restarts the pass
        at_row = 0;
        at_col = 0;
        row_acc = '0;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                            input logic t);
        wait_idle();
        write_reg(CFG_NUM_ROWS, r);
        write_reg(CFG_NUM_COLS, c);
        write_reg(CFG_TRANSPOSE, CFG_W'(t));
        elems_queued = 0;
    endtask

    initial begin
        int sel;
        int nrows;
        int ncols;
        int area;
        int n;
        int lim;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] c;
        logic             t;

        at_row = 0;
        at_col = 0;
        row_acc = '0;
        elems_queued = 0;
        words_queued = 0;
        foreach (vec_written[i]) vec_written[i] = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Normal mode 3 x 3: row 0 saturates high, row 1 saturates low, then
        // reload v[1] mid-pass so only row 2 sees the new value.
        set_dims(CFG_W'(3), CFG_W'(3), 1'b0);
        push_load(0, 32'h8000_0000);
        push_load(1, 32'h8000_0000);
        push_load(2, 32'h8000_0000);
        repeat (3) push_elem(32'h8000_0000);
        repeat (3) push_elem(32'h7FFF_FFFF);
        push_load(1, 32'h0001_0000);
        push_elem(32'h0001_0000);
        push_elem(32'hFFFF_FFFF);
        push_elem(32'h0000_0000);

        // Transpose 3 x 2: column sums built over three rows, one saturates.
        set_dims(CFG_W'(3), CFG_W'(2), 1'b1);
        push_elem(32'h8000_0000);
        push_elem(32'h8000_0000);
        push_elem(32'h7FFF_FFFF);
        push_elem(32'h8000_0000);
        push_elem(32'h8000_0000);
        push_elem(32'h7FFF_FFFF);

        // Clamped dimensions: zero rows acts as one, 2047 columns as 1024.
        set_dims(CFG_W'(0), CFG_W'(2047), 1'b1);
        push_load(1023, 32'h5A5A_A5A5);
        push_elem(32'hFFFF_FFFF);
        push_elem(32'h7FFF_FFFF);
        set_dims(CFG_W'(2047), CFG_W'(0), 1'b0);
        push_elem(32'h8000_0000);
        push_elem(32'h0000_0001);

        // Random phases: mostly small matrices run for whole passes, now and
        // then a clamped or odd dimension with a partial pass.
        while (words_queued < RANDOM_WORDS) begin
            sel = $urandom_range(0, 9);
            t = $urandom_range(0, 1);
            if (sel == 0) begin
                r = pick_extreme_dim();
                c = CFG_W'($urandom_range(1, 4));
            end else if (sel == 1) begin
                r = CFG_W'($urandom_range(1, 4));
                c = pick_extreme_dim();
            end else begin
                r = CFG_W'($urandom_range(1, 6));
                c = CFG_W'($urandom_range(1, 6));
            end
            set_dims(r, c, t);
            nrows = dim_of(r);
            ncols = dim_of(c);
            area = nrows * ncols;
            if (area <= 36) begin
                n = area * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n -= $urandom_range(0, area - 1);
            end else begin
                n = $urandom_range(1, 40);
            end
            lim = t ? nrows : ncols;
            for (int k = 0; k < n; k++) begin
                // stray load anywhere in the store
                if ($urandom_range(0, 5) == 0)
                    push_load($urandom_range(0, MAX_DIM - 1), pick_value());
                // reload an entry this pass reads, possibly mid-pass
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, lim - 1), pick_value());
                push_elem(pick_value());
            end
        end

        // drain: all words in, then a bounded wait for owed sums
        while (words_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        for (int k = 0; k < 2000 && sums_due.size() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (!failed && sums_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
